// ===== hdl/mfd_pkg.sv =====
// Shared constants and types of the 2-D median filter.
package mfd_pkg;

   // Fixed field widths of the pixel words and the register port.
   localparam int CHAN_W = 8;
   localparam int NUM_CH = 3;
   localparam int FW_W = 12;
   localparam int FH_W = 13;
   localparam int FR_W = 2;
   localparam int ADDR_W = 4;
   localparam int DATA_W = 32;

   // Defaults of the top level parameters.
   localparam int DEF_MAX_WIDTH = 2048;
   localparam int DEF_MAX_RADIUS = 3;
   localparam int DEF_CHANNELS = 3;

   // Largest frame height, and register values after reset.
   localparam int MAX_HEIGHT = 4096;
   localparam int RESET_WIDTH = 640;
   localparam int RESET_HEIGHT = 480;
   localparam int RESET_RADIUS = 1;

   // One select stage per bit of a channel value.
   localparam int SEL_STAGES = CHAN_W;

   // Depth of the result queue; a power of two so the pointers wrap by themselves.
   localparam int OUT_DEPTH = 16;

   // Register indexes of the configuration port.
   typedef enum logic [1:0] {
      REG_FRAME_WIDTH   = 2'd0,
      REG_FRAME_HEIGHT  = 2'd1,
      REG_WINDOW_RADIUS = 2'd2
   } csr_index_type;

   // One result word as it waits in the result queue.
   typedef struct packed {
      logic [CHAN_W-1:0] chan0;
      logic [CHAN_W-1:0] chan1;
      logic [CHAN_W-1:0] chan2;
      logic              frame_last;
   } rsp_word_type;

endpackage

// ===== hdl/mfd_req_if.sv =====
// Input pixel channel of the median filter.
interface mfd_req_if;
   logic                       valid;
   logic                       ready;
   logic [mfd_pkg::CHAN_W-1:0] in_chan0;
   logic [mfd_pkg::CHAN_W-1:0] in_chan1;
   logic [mfd_pkg::CHAN_W-1:0] in_chan2;
   logic                       flush;

   modport source (output valid, in_chan0, in_chan1, in_chan2, flush, input ready);
   modport sink (input valid, in_chan0, in_chan1, in_chan2, flush, output ready);
endinterface

// ===== hdl/mfd_rsp_if.sv =====
// Result pixel channel of the median filter.
interface mfd_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [mfd_pkg::CHAN_W-1:0] out_chan0;
   logic [mfd_pkg::CHAN_W-1:0] out_chan1;
   logic [mfd_pkg::CHAN_W-1:0] out_chan2;
   logic                       frame_last;

   modport source (output valid, out_chan0, out_chan1, out_chan2, frame_last, input ready);
   modport sink (input valid, out_chan0, out_chan1, out_chan2, frame_last, output ready);
endinterface

// ===== hdl/median_filter_2d_unit.sv =====
// Top level of the streaming 2-D median filter with line buffers and window chain.
//
//   channel   | direction | handshake            | word
//   req_port  | in        | valid / ready        | in_chan0..2, flush
//   rsp_port  | out       | valid / ready        | out_chan0..2, frame_last
//   APB       | in / out  | psel, penable, pready| frame_width, frame_height, window_radius
//
// One word is taken per clock while ready is high; a result leaves, after the word
// that releases it, through the select pipelines and a result queue of OUT_DEPTH words.
// Each step reads and writes one column of the line buffer memory, one port each.
// For a frame smaller than its window, the window chain runs radius*width + radius
// - width*height extra steps after the last pixel, with ready low.
// Reset is synchronous and clears the control state; the line buffer has no clearing pass.
// Apart from that, ready falls only while the result queue plus the words in flight
// reach its depth.
module median_filter_2d_unit #(
   parameter int MAX_WIDTH  = mfd_pkg::DEF_MAX_WIDTH,
   parameter int MAX_RADIUS = mfd_pkg::DEF_MAX_RADIUS,
   parameter int CHANNELS   = mfd_pkg::DEF_CHANNELS
) (
   input  logic                       clock,
   input  logic                       reset,
   mfd_req_if.sink                    req_port,
   mfd_rsp_if.source                  rsp_port,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [mfd_pkg::ADDR_W-1:0] paddr,
   input  logic [mfd_pkg::DATA_W-1:0] pwdata,
   output logic [mfd_pkg::DATA_W-1:0] prdata,
   output logic                       pready
);
   import mfd_pkg::*;

   localparam int USED_CH = (CHANNELS < NUM_CH) ? CHANNELS : NUM_CH;
   localparam int PIX_W   = USED_CH * CHAN_W;
   localparam int SIDE    = 2 * MAX_RADIUS + 1;
   localparam int NWIN    = SIDE * SIDE;
   localparam int LROWS   = 2 * MAX_RADIUS;
   localparam int WORD_W  = LROWS * PIX_W;
   localparam int COL_W   = SIDE * PIX_W;
   localparam int CW      = $clog2(MAX_WIDTH);
   localparam int WW      = $clog2(MAX_WIDTH + 1);
   localparam int RW      = $clog2(MAX_RADIUS + 1);
   localparam int HRW     = $clog2(MAX_HEIGHT);
   localparam int LAGW    = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1);
   localparam int RKW     = $clog2(NWIN + 1);
   localparam int LAT     = SEL_STAGES + 1;
   localparam int OCW     = $clog2(OUT_DEPTH + 1);
   localparam int OPW     = $clog2(OUT_DEPTH);

   // Configuration registers.
   logic [FW_W-1:0] cfg_width_ff;
   logic [FH_W-1:0] cfg_height_ff;
   logic [FR_W-1:0] cfg_radius_ff;
   logic            csr_write;
   csr_index_type   csr_index;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = csr_index_type'(paddr[ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_width_ff  <= FW_W'(RESET_WIDTH);
         cfg_height_ff <= FH_W'(RESET_HEIGHT);
         cfg_radius_ff <= FR_W'(RESET_RADIUS);
      end else if (csr_write) begin
         case (csr_index)
            REG_FRAME_WIDTH:   cfg_width_ff  <= pwdata[FW_W-1:0];
            REG_FRAME_HEIGHT:  cfg_height_ff <= pwdata[FH_W-1:0];
            REG_WINDOW_RADIUS: cfg_radius_ff <= pwdata[FR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Register read back.
   always_comb begin
      case (csr_index)
         REG_FRAME_WIDTH:   prdata = DATA_W'(cfg_width_ff);
         REG_FRAME_HEIGHT:  prdata = DATA_W'(cfg_height_ff);
         REG_WINDOW_RADIUS: prdata = DATA_W'(cfg_radius_ff);
         default:           prdata = '0;
      endcase
   end

   // Geometry from the registers, clamped to the supported range.
   logic [WW-1:0]   w_cfg;
   logic [FH_W-1:0] h_cfg;
   logic [RW-1:0]   r_cfg;
   logic [LAGW-1:0] lag_cfg;
   logic [RKW-1:0]  rank_cfg;

   always_comb begin
      if (cfg_width_ff == '0) begin
         w_cfg = WW'(1);
      end else if (int'(cfg_width_ff) > MAX_WIDTH) begin
         w_cfg = WW'(MAX_WIDTH);
      end else begin
         w_cfg = WW'(cfg_width_ff);
      end
      if (cfg_height_ff == '0) begin
         h_cfg = FH_W'(1);
      end else if (int'(cfg_height_ff) > MAX_HEIGHT) begin
         h_cfg = FH_W'(MAX_HEIGHT);
      end else begin
         h_cfg = cfg_height_ff;
      end
      if (int'(cfg_radius_ff) > MAX_RADIUS) begin
         r_cfg = RW'(MAX_RADIUS);
      end else begin
         r_cfg = RW'(cfg_radius_ff);
      end
      lag_cfg  = LAGW'(int'(r_cfg) * int'(w_cfg) + int'(r_cfg));
      rank_cfg = RKW'(2 * int'(r_cfg) * (int'(r_cfg) + 1));
   end

   // Frame state.
   logic [WW-1:0]   w_ff;
   logic [FH_W-1:0] h_ff;
   logic [RW-1:0]   r_ff;
   logic [LAGW-1:0] lag_ff;
   logic [RKW-1:0]  rank_ff;
   logic [CW-1:0]   in_col_ff, in_col_in;
   logic [HRW-1:0]  in_row_ff, in_row_in;
   logic [CW-1:0]   out_col_ff, out_col_in;
   logic [HRW-1:0]  out_row_ff, out_row_in;
   logic [CW-1:0]   ccol_ff, ccol_in;
   logic [LAGW-1:0] pend_ff, pend_in;
   logic            done_ff, done_in;
   logic [OCW-1:0]  occ_ff;

   logic            first;
   logic [WW-1:0]   w_cur;
   logic [FH_W-1:0] h_cur;
   logic [RW-1:0]   r_cur;
   logic [LAGW-1:0] lag_cur;
   logic [RKW-1:0]  rank_cur;
   logic            catch_up;
   logic            accept;
   logic            is_pix;
   logic            drain_item;
   logic            step;
   logic            emit;
   logic            in_last;
   logic            out_last;
   logic            inner;
   logic            pop;

   assign first    = !done_ff && (in_row_ff == '0) && (in_col_ff == '0);
   assign w_cur    = first ? w_cfg : w_ff;
   assign h_cur    = first ? h_cfg : h_ff;
   assign r_cur    = first ? r_cfg : r_ff;
   assign lag_cur  = first ? lag_cfg : lag_ff;
   assign rank_cur = first ? rank_cfg : rank_ff;

   // Small frames: the chain steps on its own until it lines up with the next result.
   assign catch_up = done_ff && (pend_ff < lag_ff);
   assign req_port.ready = (occ_ff < OCW'(OUT_DEPTH)) && !catch_up;

   assign accept     = req_port.valid && req_port.ready;
   assign is_pix     = accept && !done_ff && !req_port.flush;
   assign drain_item = accept && done_ff;
   assign step       = is_pix || drain_item || catch_up;
   assign emit       = (is_pix && (pend_ff == lag_cur)) || drain_item;

   assign in_last  = (FH_W'(in_row_ff) + FH_W'(1) == h_cur) &&
                     (WW'(in_col_ff) + WW'(1) == w_cur);
   assign out_last = (FH_W'(out_row_ff) + FH_W'(1) == h_cur) &&
                     ((WW+1)'(out_col_ff) + (WW+1)'(1) == (WW+1)'(w_cur));
   assign inner    = (r_cur != '0) &&
                     (FH_W'(out_row_ff) >= FH_W'(r_cur)) &&
                     (FH_W'(out_row_ff) + FH_W'(r_cur) < h_cur) &&
                     ((WW+1)'(out_col_ff) >= (WW+1)'(r_cur)) &&
                     ((WW+1)'(out_col_ff) + (WW+1)'(r_cur) < (WW+1)'(w_cur));

   // Counter updates for one step.
   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      ccol_in    = ccol_ff;
      pend_in    = pend_ff;
      done_in    = done_ff;
      if (step) begin
         if (WW'(ccol_ff) + WW'(1) == w_cur) begin
            ccol_in = '0;
         end else begin
            ccol_in = ccol_ff + CW'(1);
         end
         if (!emit) begin
            pend_in = pend_ff + LAGW'(1);
         end
      end
      if (is_pix) begin
         if (in_last) begin
            done_in = 1'b1;
         end else if (WW'(in_col_ff) + WW'(1) == w_cur) begin
            in_col_in = '0;
            in_row_in = in_row_ff + HRW'(1);
         end else begin
            in_col_in = in_col_ff + CW'(1);
         end
      end
      if (emit) begin
         if ((WW+1)'(out_col_ff) + (WW+1)'(1) == (WW+1)'(w_cur)) begin
            out_col_in = '0;
            out_row_in = out_row_ff + HRW'(1);
         end else begin
            out_col_in = out_col_ff + CW'(1);
         end
         if (out_last) begin
            in_col_in  = '0;
            in_row_in  = '0;
            out_col_in = '0;
            out_row_in = '0;
            ccol_in    = '0;
            pend_in    = '0;
            done_in    = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         ccol_ff    <= '0;
         pend_ff    <= '0;
         done_ff    <= 1'b0;
         w_ff       <= '0;
         h_ff       <= '0;
         r_ff       <= '0;
         lag_ff     <= '0;
         rank_ff    <= '0;
      end else begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         ccol_ff    <= ccol_in;
         pend_ff    <= pend_in;
         done_ff    <= done_in;
         if (is_pix && first) begin
            w_ff    <= w_cfg;
            h_ff    <= h_cfg;
            r_ff    <= r_cfg;
            lag_ff  <= lag_cfg;
            rank_ff <= rank_cfg;
         end
      end
   end

   // New column: the incoming pixel on top of the older rows of its column.
   logic [CHAN_W-1:0] in_ch [NUM_CH];
   logic [PIX_W-1:0]  pix;
   logic [WORD_W-1:0] rd_word;
   logic [COL_W-1:0]  new_col;

   assign in_ch[0] = req_port.in_chan0;
   assign in_ch[1] = req_port.in_chan1;
   assign in_ch[2] = req_port.in_chan2;

   always_comb begin
      for (int c = 0; c < USED_CH; c++) begin
         pix[c*CHAN_W +: CHAN_W] = is_pix ? in_ch[c] : '0;
      end
      new_col[0 +: PIX_W] = pix;
      new_col[PIX_W +: WORD_W] = rd_word;
   end

   mfd_line_buf #(
      .DEPTH  (MAX_WIDTH),
      .WORD_W (WORD_W)
   ) u_line_buf (
      .clock   (clock),
      .wr_en   (step),
      .wr_addr (ccol_ff),
      .wr_data (new_col[0 +: WORD_W]),
      .rd_addr (ccol_in),
      .rd_data (rd_word)
   );

   // Window chain: column k of the window is the column seen k steps ago.
   logic [COL_W-1:0] chain_q [LROWS];
   logic [COL_W-1:0] wcol    [SIDE];

   for (genvar k = 0; k < LROWS; k++) begin : g_chain
      mfd_cell #(
         .COL_W (COL_W)
      ) u_col (
         .clock    (clock),
         .shift_en (step),
         .col_in   ((k == 0) ? new_col : chain_q[(k == 0) ? 0 : k-1]),
         .col_out  (chain_q[k])
      );
   end

   always_comb begin
      wcol[0] = new_col;
      for (int k = 1; k < SIDE; k++) begin
         wcol[k] = chain_q[k-1];
      end
   end

   // Center pixel and live window positions for the current radius.
   logic [PIX_W-1:0] self_pix;
   logic [NWIN-1:0]  alive;

   always_comb begin
      self_pix = wcol[0][0 +: PIX_W];
      for (int k = 1; k <= MAX_RADIUS; k++) begin
         if (r_cur == RW'(k)) begin
            self_pix = wcol[k][k*PIX_W +: PIX_W];
         end
      end
      for (int j = 0; j < SIDE; j++) begin
         for (int k = 0; k < SIDE; k++) begin
            alive[j*SIDE + k] = (j <= 2 * int'(r_cur)) && (k <= 2 * int'(r_cur));
         end
      end
   end

   // One rank select pipeline per channel.
   logic [CHAN_W-1:0] med [USED_CH];

   for (genvar c = 0; c < USED_CH; c++) begin : g_chan
      logic [NWIN*CHAN_W-1:0] vals;
      always_comb begin
         for (int j = 0; j < SIDE; j++) begin
            for (int k = 0; k < SIDE; k++) begin
               vals[(j*SIDE + k)*CHAN_W +: CHAN_W] = wcol[k][j*PIX_W + c*CHAN_W +: CHAN_W];
            end
         end
      end
      mfd_select #(
         .NWIN (NWIN),
         .RKW  (RKW)
      ) u_select (
         .clock  (clock),
         .vals   (vals),
         .alive  (alive),
         .rank   (rank_cur),
         .median (med[c])
      );
   end

   // Side data travels alongside the select pipelines.
   logic             sb_valid_ff [LAT];
   logic [PIX_W-1:0] sb_self_ff  [LAT];
   logic             sb_inner_ff [LAT];
   logic             sb_last_ff  [LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LAT; i++) begin
            sb_valid_ff[i] <= 1'b0;
         end
      end else begin
         sb_valid_ff[0] <= emit;
         for (int i = 1; i < LAT; i++) begin
            sb_valid_ff[i] <= sb_valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      sb_self_ff[0]  <= self_pix;
      sb_inner_ff[0] <= inner;
      sb_last_ff[0]  <= out_last;
      for (int i = 1; i < LAT; i++) begin
         sb_self_ff[i]  <= sb_self_ff[i-1];
         sb_inner_ff[i] <= sb_inner_ff[i-1];
         sb_last_ff[i]  <= sb_last_ff[i-1];
      end
   end

   // Final pick: median inside the frame, a copy of the pixel at the border.
   logic [CHAN_W-1:0] res_ch [NUM_CH];
   rsp_word_type      push_word;

   always_comb begin
      for (int c = 0; c < NUM_CH; c++) begin
         res_ch[c] = '0;
      end
      for (int c = 0; c < USED_CH; c++) begin
         res_ch[c] = sb_inner_ff[LAT-1] ? med[c] : sb_self_ff[LAT-1][c*CHAN_W +: CHAN_W];
      end
      push_word.chan0      = res_ch[0];
      push_word.chan1      = res_ch[1];
      push_word.chan2      = res_ch[2];
      push_word.frame_last = sb_last_ff[LAT-1];
   end

   // Result queue; occupancy counts queued words plus words still in flight.
   rsp_word_type   fifo_ff [OUT_DEPTH];
   logic [OPW-1:0] wr_ptr_ff;
   logic [OPW-1:0] rd_ptr_ff;
   logic [OCW-1:0] cnt_ff;
   logic           push;
   rsp_word_type   head;

   assign push = sb_valid_ff[LAT-1];
   assign pop  = rsp_port.valid && rsp_port.ready;
   assign head = fifo_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= push_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
         occ_ff    <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + OPW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + OPW'(1);
         end
         cnt_ff <= cnt_ff + OCW'(push) - OCW'(pop);
         occ_ff <= occ_ff + OCW'(emit) - OCW'(pop);
      end
   end

   assign rsp_port.valid      = (cnt_ff != '0);
   assign rsp_port.out_chan0  = head.chan0;
   assign rsp_port.out_chan1  = head.chan1;
   assign rsp_port.out_chan2  = head.chan2;
   assign rsp_port.frame_last = head.frame_last;

`ifndef ASSERT_OFF
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCW'(OUT_DEPTH))
      else $error("result queue plus in-flight words exceed the queue depth");

   a_queue_within_occ: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= occ_ff)
      else $error("queued words exceed the words counted as outstanding");

   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff <= lag_ff)
      else $error("window chain ran ahead of the result position");

   a_no_take_in_catch_up: assert property (@(posedge clock) disable iff (reset)
      (done_ff && (pend_ff < lag_ff)) |-> !req_port.ready)
      else $error("word taken while the window chain catches up");
`endif
endmodule

// ===== hdl/mfd_line_buf.sv =====
// Line buffer memory: one word per column holds the older rows of that column.
module mfd_line_buf #(
   parameter int DEPTH  = 2048,
   parameter int WORD_W = 144
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WORD_W-1:0]        wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WORD_W-1:0]        rd_data
);
   logic [WORD_W-1:0] mem [DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read; a write to the same column in this cycle is forwarded.
   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== hdl/mfd_cell.sv =====
// One window column of the sliding window chain; hands its column on at each step.
module mfd_cell #(
   parameter int COL_W = 168
) (
   input  logic             clock,
   input  logic             shift_en,
   input  logic [COL_W-1:0] col_in,
   output logic [COL_W-1:0] col_out
);
   logic [COL_W-1:0] col_ff;

   // Take the neighbor's column whenever the window slides.
   always_ff @(posedge clock) begin
      if (shift_en) begin
         col_ff <= col_in;
      end
   end

   assign col_out = col_ff;
endmodule

// ===== hdl/mfd_select.sv =====
// Pipelined rank select over one channel of the window, one result bit per stage.
module mfd_select #(
   parameter int NWIN = 49,
   parameter int RKW  = 6
) (
   input  logic                             clock,
   input  logic [NWIN*mfd_pkg::CHAN_W-1:0]  vals,
   input  logic [NWIN-1:0]                  alive,
   input  logic [RKW-1:0]                   rank,
   output logic [mfd_pkg::CHAN_W-1:0]       median
);
   import mfd_pkg::*;

   logic [NWIN*CHAN_W-1:0] vals_ff  [SEL_STAGES+1];
   logic [NWIN-1:0]        alive_ff [SEL_STAGES+1];
   logic [RKW-1:0]         rank_ff  [SEL_STAGES+1];
   logic [CHAN_W-1:0]      med_ff   [SEL_STAGES+1];

   // Capture the window, the set of live entries and the wanted rank.
   always_ff @(posedge clock) begin
      vals_ff[0]  <= vals;
      alive_ff[0] <= alive;
      rank_ff[0]  <= rank;
      med_ff[0]   <= '0;
   end

   // Each stage settles one bit, from the top down: count the live entries with a
   // zero there; if the rank falls among them the bit is zero, else it is one.
   for (genvar s = 0; s < SEL_STAGES; s++) begin : g_stage
      localparam int B = CHAN_W - 1 - s;
      logic [NWIN-1:0]   bit_col;
      logic [NWIN-1:0]   zero_set;
      logic [RKW-1:0]    zero_cnt;
      logic              pick_one;
      logic [CHAN_W-1:0] med_in;

      always_comb begin
         for (int i = 0; i < NWIN; i++) begin
            bit_col[i] = vals_ff[s][i*CHAN_W + B];
         end
         zero_set = alive_ff[s] & ~bit_col;
         zero_cnt = RKW'($countones(zero_set));
         pick_one = (rank_ff[s] >= zero_cnt);
         med_in = med_ff[s];
         med_in[B] = pick_one;
      end

      always_ff @(posedge clock) begin
         vals_ff[s+1]  <= vals_ff[s];
         alive_ff[s+1] <= pick_one ? (alive_ff[s] & bit_col) : zero_set;
         rank_ff[s+1]  <= pick_one ? (rank_ff[s] - zero_cnt) : rank_ff[s];
         med_ff[s+1]   <= med_in;
      end
   end

   assign median = med_ff[SEL_STAGES];
endmodule
